FILE: rtl/dpx_pkg.sv
// ----------------------------------------------------------------------------
// dpx_pkg
// Shared widths, register codes, reset values and types for the depth pixel
// to xyz back-projection pipeline.
// ----------------------------------------------------------------------------
package dpx_pkg;

   // field widths
   localparam int COORD_BITS  = 12;
   localparam int DEPTH_BITS  = 16;
   localparam int REG_BITS    = 12;
   localparam int OFFSET_BITS = 16;
   localparam int CODE_BITS   = 16;
   localparam int COLOR_BITS  = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // derived datapath widths
   localparam int DIFF_BITS = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
   localparam int PROD_BITS = DEPTH_BITS + DIFF_BITS;

   // divider: quotient bits retired per stage and stage count
   localparam int DIV_STEPS      = 4;
   localparam int DIV_STAGES     = (PROD_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DQ_BITS        = DIV_STAGES * DIV_STEPS;

   // input register, product, divider stages, output register
   localparam int LATENCY = DIV_STAGES + 3;

   // register reset values
   localparam logic [REG_BITS-1:0]    FOCAL_X_RST  = REG_BITS'(931);
   localparam logic [REG_BITS-1:0]    FOCAL_Y_RST  = REG_BITS'(931);
   localparam logic [REG_BITS-1:0]    CENTER_X_RST = REG_BITS'(965);
   localparam logic [REG_BITS-1:0]    CENTER_Y_RST = REG_BITS'(548);
   localparam logic [OFFSET_BITS-1:0] OFFSET_RST   = OFFSET_BITS'(1000 * 20);

   // register index codes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FOCAL_X  = 3'd0,
      CSR_FOCAL_Y  = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_OFFSET   = 3'd4
   } csr_index_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [REG_BITS-1:0]    focal_x;
      logic [REG_BITS-1:0]    focal_y;
      logic [REG_BITS-1:0]    center_x;
      logic [REG_BITS-1:0]    center_y;
      logic [OFFSET_BITS-1:0] offset;
   } cfg_type;

   // one divider stage word: partial remainder, dividend/quotient shifter, sign
   typedef struct packed {
      logic [REG_BITS-1:0] rem;
      logic [DQ_BITS-1:0]  dq;
      logic                neg;
   } div_type;

   // pass-through fields riding beside the datapath
   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } side_type;

endpackage

FILE: rtl/dpx_csr.sv
// ----------------------------------------------------------------------------
// dpx_csr
// Configuration register bank: focal lengths, principal point and bias.
// ----------------------------------------------------------------------------
module dpx_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dpx_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [dpx_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output dpx_pkg::cfg_type                     cfg
);

   dpx_pkg::cfg_type cfg_ff;
   dpx_pkg::cfg_type cfg_in;

   // writes are always accepted
   assign csr_ready = 1'b1;

   // next register values, writes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dpx_pkg::CSR_FOCAL_X:  cfg_in.focal_x  = csr_data[dpx_pkg::REG_BITS-1:0];
            dpx_pkg::CSR_FOCAL_Y:  cfg_in.focal_y  = csr_data[dpx_pkg::REG_BITS-1:0];
            dpx_pkg::CSR_CENTER_X: cfg_in.center_x = csr_data[dpx_pkg::REG_BITS-1:0];
            dpx_pkg::CSR_CENTER_Y: cfg_in.center_y = csr_data[dpx_pkg::REG_BITS-1:0];
            dpx_pkg::CSR_OFFSET:   cfg_in.offset   = csr_data[dpx_pkg::OFFSET_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x  <= dpx_pkg::FOCAL_X_RST;
         cfg_ff.focal_y  <= dpx_pkg::FOCAL_Y_RST;
         cfg_ff.center_x <= dpx_pkg::CENTER_X_RST;
         cfg_ff.center_y <= dpx_pkg::CENTER_Y_RST;
         cfg_ff.offset   <= dpx_pkg::OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/dpx_div_stage.sv
// ----------------------------------------------------------------------------
// dpx_div_stage
// One registered stage of the restoring divider, retiring DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module dpx_div_stage (
   input  logic                          clock,
   input  dpx_pkg::div_type              div_in,
   input  logic [dpx_pkg::REG_BITS-1:0]  divisor,
   output dpx_pkg::div_type              div_out
);

   dpx_pkg::div_type div_ff;
   dpx_pkg::div_type div_nx_in;

   // shift-compare-subtract steps
   always_comb begin
      logic [dpx_pkg::REG_BITS:0] part;
      div_nx_in = div_in;
      part      = '0;
      for (int i = 0; i < dpx_pkg::DIV_STEPS; i++) begin
         part         = {div_nx_in.rem, div_nx_in.dq[dpx_pkg::DQ_BITS-1]};
         div_nx_in.dq = {div_nx_in.dq[dpx_pkg::DQ_BITS-2:0], 1'b0};
         if (part >= {1'b0, divisor}) begin
            part            = part - {1'b0, divisor};
            div_nx_in.dq[0] = 1'b1;
         end
         div_nx_in.rem = part[dpx_pkg::REG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_nx_in;
   end

   assign div_out = div_ff;

endmodule

FILE: rtl/dpx_axis.sv
// ----------------------------------------------------------------------------
// dpx_axis
// Back-projection of one image axis: offset from centre, scale by depth,
// pipelined divide by focal length, sign and bias.
// ----------------------------------------------------------------------------
module dpx_axis (
   input  logic                             clock,
   input  logic [dpx_pkg::COORD_BITS-1:0]   pos,
   input  logic [dpx_pkg::DEPTH_BITS-1:0]   depth,
   input  logic [dpx_pkg::REG_BITS-1:0]     center,
   input  logic [dpx_pkg::REG_BITS-1:0]     focal,
   input  logic [dpx_pkg::OFFSET_BITS-1:0]  offset,
   output logic [dpx_pkg::CODE_BITS-1:0]    code
);

   logic [dpx_pkg::DIFF_BITS-1:0]  pos_ext;
   logic [dpx_pkg::DIFF_BITS-1:0]  ctr_ext;
   logic                           neg_in;
   logic [dpx_pkg::DIFF_BITS-1:0]  diff_in;
   logic                           neg_a_ff;
   logic [dpx_pkg::DIFF_BITS-1:0]  diff_ff;
   logic [dpx_pkg::DEPTH_BITS-1:0] depth_ff;
   logic                           neg_b_ff;
   logic [dpx_pkg::PROD_BITS-1:0]  prod_ff;
   dpx_pkg::div_type               chain [dpx_pkg::DIV_STAGES+1];
   logic [dpx_pkg::CODE_BITS-1:0]  mag;
   logic [dpx_pkg::CODE_BITS-1:0]  code_in;
   logic [dpx_pkg::CODE_BITS-1:0]  code_ff;

   // magnitude and sign of the distance from the principal point
   assign pos_ext = dpx_pkg::DIFF_BITS'(pos);
   assign ctr_ext = dpx_pkg::DIFF_BITS'(center);
   assign neg_in  = pos_ext < ctr_ext;
   assign diff_in = neg_in ? (ctr_ext - pos_ext) : (pos_ext - ctr_ext);

   always_ff @(posedge clock) begin
      neg_a_ff <= neg_in;
      diff_ff  <= diff_in;
      depth_ff <= depth;
   end

   // scale by depth
   always_ff @(posedge clock) begin
      neg_b_ff <= neg_a_ff;
      prod_ff  <= dpx_pkg::PROD_BITS'(depth_ff) * dpx_pkg::PROD_BITS'(diff_ff);
   end

   // divider chain, dividend zero-padded to a whole number of stages
   assign chain[0].rem = '0;
   assign chain[0].dq  = dpx_pkg::DQ_BITS'(prod_ff);
   assign chain[0].neg = neg_b_ff;

   for (genvar g = 0; g < dpx_pkg::DIV_STAGES; g++) begin : g_div
      dpx_div_stage u_stage (
         .clock   (clock),
         .div_in  (chain[g]),
         .divisor (focal),
         .div_out (chain[g+1])
      );
   end

   // apply sign and bias, zero focal gives a zero term
   assign mag     = (focal == '0) ? '0
                  : chain[dpx_pkg::DIV_STAGES].dq[dpx_pkg::CODE_BITS-1:0];
   assign code_in = offset + (chain[dpx_pkg::DIV_STAGES].neg
                              ? (~mag + dpx_pkg::CODE_BITS'(1)) : mag);

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

FILE: rtl/depth_pixel_to_xyz_top.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_xyz_top
// Throughput: one pixel per cycle outside reset; the seven-stage divider
// retires four quotient bits per stage.
// Reset: synchronous; clears the valid pipeline, loads register defaults and
// holds busy high. The receiver cannot stall: each word is strobed once.
// ----------------------------------------------------------------------------
module depth_pixel_to_xyz_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // pixel request
   input  logic                                 start,
   output logic                                 busy,
   input  logic [dpx_pkg::COORD_BITS-1:0]       req_column,
   input  logic [dpx_pkg::COORD_BITS-1:0]       req_row,
   input  logic [dpx_pkg::DEPTH_BITS-1:0]       req_depth,
   input  logic [dpx_pkg::COLOR_BITS-1:0]       req_red_in,
   input  logic [dpx_pkg::COLOR_BITS-1:0]       req_green_in,
   input  logic [dpx_pkg::COLOR_BITS-1:0]       req_blue_in,
   // point response
   output logic                                 rsp_valid,
   output logic [dpx_pkg::CODE_BITS-1:0]        rsp_x_code,
   output logic [dpx_pkg::CODE_BITS-1:0]        rsp_y_code,
   output logic [dpx_pkg::CODE_BITS-1:0]        rsp_z_code,
   output logic [dpx_pkg::COLOR_BITS-1:0]       rsp_red_out,
   output logic [dpx_pkg::COLOR_BITS-1:0]       rsp_green_out,
   output logic [dpx_pkg::COLOR_BITS-1:0]       rsp_blue_out,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dpx_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [dpx_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   dpx_pkg::cfg_type  cfg;
   logic              accept;
   dpx_pkg::side_type side_in;
   logic              valid_ff [dpx_pkg::LATENCY];
   dpx_pkg::side_type side_ff  [dpx_pkg::LATENCY];
   dpx_pkg::side_type side_out;

   // configuration registers
   dpx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // pipeline takes a word every cycle outside reset
   assign busy   = reset;
   assign accept = start && !busy;

   // x and y datapaths
   dpx_axis u_axis_x (
      .clock  (clock),
      .pos    (req_column),
      .depth  (req_depth),
      .center (cfg.center_x),
      .focal  (cfg.focal_x),
      .offset (cfg.offset),
      .code   (rsp_x_code)
   );

   dpx_axis u_axis_y (
      .clock  (clock),
      .pos    (req_row),
      .depth  (req_depth),
      .center (cfg.center_y),
      .focal  (cfg.focal_y),
      .offset (cfg.offset),
      .code   (rsp_y_code)
   );

   // valid bits travel alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dpx_pkg::LATENCY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int i = 1; i < dpx_pkg::LATENCY; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // depth and colour delay line
   assign side_in.depth = req_depth;
   assign side_in.red   = req_red_in;
   assign side_in.green = req_green_in;
   assign side_in.blue  = req_blue_in;

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < dpx_pkg::LATENCY; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // response word
   assign side_out      = side_ff[dpx_pkg::LATENCY-1];
   assign rsp_valid     = valid_ff[dpx_pkg::LATENCY-1];
   assign rsp_z_code    = dpx_pkg::CODE_BITS'(side_out.depth);
   assign rsp_red_out   = side_out.red;
   assign rsp_green_out = side_out.green;
   assign rsp_blue_out  = side_out.blue;

endmodule
